[rtl/mexp_pkg.sv]
// shared types, constants and microcode table for the modular exponentiation core
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// number of low exponent bits scanned
	localparam int EXP_BITS = 63;
	localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(EXP_BITS - 1);

	// modulus and reduction constants
	localparam logic [29:0] PRIME = 30'd1000000007;
	localparam logic [31:0] TWO_PRIME = 32'd2000000014;
	// floor(2^60 / prime) for the quotient estimate
	localparam logic [30:0] MU = 31'd1152921496;
	// 2^33 mod prime, folds the high part of a raw base
	localparam logic [30:0] C33 = 31'd589934536;

	// microcode address space
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LOOP = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LOOP_END = 4'd15;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQ,
		MUL_AB,
		MUL_MU,
		MUL_Q,
		MUL_RAW
	} mul_op_t;

	// what lands in the value register being reduced
	typedef enum logic [1:0] {
		XW_NONE,
		XW_PROD,
		XW_PROD_LO
	} xw_t;

	// destination of a fully reduced value
	typedef enum logic [1:0] {
		DST_NONE,
		DST_BASE,
		DST_ACC
	} dst_t;

	// sequencing of the step counter
	typedef enum logic [1:0] {
		BR_NEXT,
		BR_SKIP,
		BR_LOOP
	} br_t;

	typedef struct packed {
		mul_op_t          mul_op;
		xw_t              x_wr;
		logic             prod_wr;
		logic             r_wr;
		dst_t             dst;
		br_t              br;
		logic [STEP_W-1:0] target;
	} ucode_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic    load;
		logic    shift;
		mul_op_t mul_op;
		xw_t     x_wr;
		logic    prod_wr;
		logic    r_wr;
		dst_t    dst;
	} ctrl_t;

	// datapath to sequencer status
	typedef struct packed {
		logic        bit_hi;
		logic [29:0] acc;
	} stat_t;

	function automatic ucode_t mk(input mul_op_t mul_op, input xw_t x_wr, input logic prod_wr,
			input logic r_wr, input dst_t dst, input br_t br, input logic [STEP_W-1:0] target);
		ucode_t w;
		w.mul_op = mul_op;
		w.x_wr = x_wr;
		w.prod_wr = prod_wr;
		w.r_wr = r_wr;
		w.dst = dst;
		w.br = br;
		w.target = target;
		return w;
	endfunction

	// control store: base fold, then square and conditional multiply per exponent bit
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			4'd0: w = mk(MUL_RAW, XW_PROD_LO, 1'b0, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd1: w = mk(MUL_MU, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd2: w = mk(MUL_Q, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd3: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b1, DST_NONE, BR_NEXT, '0);
			4'd4: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b0, DST_BASE, BR_NEXT, '0);
			4'd5: w = mk(MUL_SQ, XW_PROD, 1'b0, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd6: w = mk(MUL_MU, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd7: w = mk(MUL_Q, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd8: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b1, DST_NONE, BR_NEXT, '0);
			4'd9: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b0, DST_ACC, BR_SKIP, STEP_LOOP_END);
			4'd10: w = mk(MUL_AB, XW_PROD, 1'b0, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd11: w = mk(MUL_MU, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd12: w = mk(MUL_Q, XW_NONE, 1'b1, 1'b0, DST_NONE, BR_NEXT, '0);
			4'd13: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b1, DST_NONE, BR_NEXT, '0);
			4'd14: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b0, DST_ACC, BR_NEXT, '0);
			4'd15: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b0, DST_NONE, BR_LOOP, STEP_LOOP);
			default: w = mk(MUL_NONE, XW_NONE, 1'b0, 1'b0, DST_NONE, BR_NEXT, '0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/modular_exponentiation_prime_core.sv]
// top level: microcoded sequencer and output register for base^exponent mod 1000000007
`timescale 1ns / 1ps
`default_nettype none

// Computes base^exponent mod 1000000007 for one transaction at a time. After a transaction
// is taken the base is folded and reduced, then each of the 63 exponent bits, most
// significant first, is handled by a squaring plus a multiply by the base when the bit is
// set. When the last bit is done the result is registered on the output, once the previous
// result has been read; a new transaction is taken in the cycle after that, never before the
// current one is through. Every modular product, the two multiplies of its reduction step
// and the base fold share the single 31x31 multiplier. A finished result waits in its own
// register, so the next transaction is taken while the previous result is still unread.
module modular_exponentiation_prime_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [62:0] base,
	input  wire logic [62:0] exponent,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [29:0]      power_mod
);

	logic                          busy_q;
	logic [mexp_pkg::STEP_W-1:0]   step_q;
	logic [mexp_pkg::CNT_W-1:0]    cnt_q;
	logic                          out_valid_q;
	logic [29:0]                   result_q;

	mexp_pkg::ucode_t uc;
	mexp_pkg::ctrl_t  ctrl;
	mexp_pkg::stat_t  status;
	logic             accept;
	logic             out_free;
	logic             more_bits;
	logic             finish;

	assign uc = mexp_pkg::ucode(step_q);
	assign in_ready = !busy_q;
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign more_bits = (cnt_q != '0);
	assign finish = busy_q && (uc.br == mexp_pkg::BR_LOOP) && !more_bits && out_free;

	// control word gated by activity
	always_comb begin
		ctrl.load = accept;
		ctrl.shift = busy_q && (uc.br == mexp_pkg::BR_LOOP) && more_bits;
		ctrl.mul_op = busy_q ? uc.mul_op : mexp_pkg::MUL_NONE;
		ctrl.x_wr = busy_q ? uc.x_wr : mexp_pkg::XW_NONE;
		ctrl.prod_wr = busy_q && uc.prod_wr;
		ctrl.r_wr = busy_q && uc.r_wr;
		ctrl.dst = busy_q ? uc.dst : mexp_pkg::DST_NONE;
	end

	mexp_datapath u_datapath (
		.clk      (clk),
		.ctrl     (ctrl),
		.base     (base),
		.exponent (exponent),
		.status   (status)
	);

	// step counter, bit counter and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
				cnt_q <= mexp_pkg::CNT_INIT;
			end else if (busy_q) begin
				case (uc.br)
					mexp_pkg::BR_SKIP: begin
						step_q <= status.bit_hi ? step_q + 1'b1 : uc.target;
					end
					mexp_pkg::BR_LOOP: begin
						if (more_bits) begin
							cnt_q <= cnt_q - 1'b1;
							step_q <= uc.target;
						end else if (out_free) begin
							busy_q <= 1'b0;
							step_q <= '0;
						end
					end
					default: begin
						step_q <= step_q + 1'b1;
					end
				endcase
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= status.acc;
		end
	end

	assign out_valid = out_valid_q;
	assign power_mod = result_q;

`ifndef ASSERT_OFF
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (power_mod < mexp_pkg::PRIME))
		else $error("result not reduced below the prime");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && (step_q == '0) && (cnt_q == mexp_pkg::CNT_INIT)))
		else $error("sequencer did not start at step zero");

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (step_q == '0))
		else $error("step counter moved while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(result_q)))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[rtl/mexp_datapath.sv]
// datapath: shared multiplier, barrett reduction registers, base, accumulator, exponent
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath (
	input  wire logic                         clk,
	input  wire mexp_pkg::ctrl_t              ctrl,
	input  wire logic [62:0]                  base,
	input  wire logic [62:0]                  exponent,
	output mexp_pkg::stat_t                   status
);

	logic [62:0]                   raw_q;
	logic [29:0]                   base_q;
	logic [29:0]                   acc_q;
	logic [mexp_pkg::EXP_BITS-1:0] exp_q;
	logic [59:0]                   x_q;
	logic [61:0]                   prod_q;
	logic [31:0]                   r_q;

	logic [30:0] mul_a;
	logic [30:0] mul_b;
	logic [61:0] product;
	logic [29:0] reduced;

	// operand select for the shared multiplier
	always_comb begin
		case (ctrl.mul_op)
			mexp_pkg::MUL_SQ: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, acc_q};
			end
			mexp_pkg::MUL_AB: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, base_q};
			end
			mexp_pkg::MUL_MU: begin
				mul_a = x_q[59:29];
				mul_b = mexp_pkg::MU;
			end
			mexp_pkg::MUL_Q: begin
				mul_a = prod_q[61:31];
				mul_b = {1'b0, mexp_pkg::PRIME};
			end
			mexp_pkg::MUL_RAW: begin
				mul_a = {1'b0, raw_q[62:33]};
				mul_b = mexp_pkg::C33;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = 62'(mul_a) * 62'(mul_b);

	// final correction: remainder estimate is below three times the prime
	always_comb begin
		if (r_q >= mexp_pkg::TWO_PRIME) begin
			reduced = 30'(r_q - mexp_pkg::TWO_PRIME);
		end else if (r_q >= 32'(mexp_pkg::PRIME)) begin
			reduced = 30'(r_q - 32'(mexp_pkg::PRIME));
		end else begin
			reduced = r_q[29:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			raw_q <= base;
			exp_q <= exponent[mexp_pkg::EXP_BITS-1:0];
			acc_q <= 30'd1;
		end else begin
			if (ctrl.shift) begin
				exp_q <= exp_q << 1;
			end
			case (ctrl.dst)
				mexp_pkg::DST_BASE: base_q <= reduced;
				mexp_pkg::DST_ACC:  acc_q <= reduced;
				default: ;
			endcase
		end
		case (ctrl.x_wr)
			mexp_pkg::XW_PROD:    x_q <= product[59:0];
			mexp_pkg::XW_PROD_LO: x_q <= product[59:0] + 60'(raw_q[32:0]);
			default: ;
		endcase
		if (ctrl.prod_wr) begin
			prod_q <= product;
		end
		// remainder fits in 32 bits, so low words suffice
		if (ctrl.r_wr) begin
			r_q <= x_q[31:0] - prod_q[31:0];
		end
	end

	assign status.bit_hi = exp_q[mexp_pkg::EXP_BITS-1];
	assign status.acc = acc_q;

endmodule

`default_nettype wire
